// File: rtl/ogec_pkg.sv
`timescale 1ns / 1ps
package ogec_pkg;
  localparam int unsigned SymbolCountDefault = 256;
  localparam int unsigned GreekWidthDefault  = 24;

  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CfgMult     = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxDelta = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgMaxGamma = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgThetaFlr = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgVixPct   = 3'd4;

  localparam logic [1:0] KindGreeks = 2'd0;
  localparam logic [1:0] KindOrder  = 2'd1;
  localparam logic [1:0] KindFill   = 2'd2;
  localparam logic [1:0] KindVix    = 2'd3;

  localparam logic [2:0] RsnNone  = 3'd0;
  localparam logic [2:0] RsnBase  = 3'd1;
  localparam logic [2:0] RsnDelta = 3'd2;
  localparam logic [2:0] RsnGamma = 3'd3;
  localparam logic [2:0] RsnTheta = 3'd4;

  localparam logic signed [63:0] SMax = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] SMin = 64'sh8000_0000_0000_0000;
  localparam logic [22:0] PctScale = 23'd6553600;

  typedef struct packed {
    logic       accepted;
    logic [2:0] reject_reason;
    logic       kill_switch;
  } result_t;

  function automatic logic signed [63:0] sat_add(logic signed [63:0] a,
                                                 logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return SMax;
    if (s < -65'sh0_8000_0000_0000_0000) return SMin;
    return s[63:0];
  endfunction

  function automatic logic [63:0] mag(logic signed [63:0] x);
    return x[63] ? (64'd0 - x) : x;
  endfunction
endpackage

// File: rtl/ogec_if.sv
`timescale 1ns / 1ps
interface ogec_in_if #(parameter int GW = 24);
  logic          valid;
  logic          ready;
  logic [1:0]    kind;
  logic [7:0]    symbol;
  logic          side;
  logic [23:0]   quantity;
  logic          base_ok;
  logic signed [GW-1:0] delta_in;
  logic signed [GW-1:0] gamma_in;
  logic signed [GW-1:0] theta_in;
  logic [31:0]   vix_level;
  modport source(output valid, kind, symbol, side, quantity, base_ok, delta_in,
                 gamma_in, theta_in, vix_level, input ready);
  modport sink(input valid, kind, symbol, side, quantity, base_ok, delta_in,
               gamma_in, theta_in, vix_level, output ready);
endinterface

interface ogec_out_if;
  logic       valid;
  logic       ready;
  logic       accepted;
  logic [2:0] reject_reason;
  logic       kill_switch;
  modport source(output valid, accepted, reject_reason, kill_switch, input ready);
  modport sink(input valid, accepted, reject_reason, kill_switch, output ready);
endinterface

interface ogec_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// File: rtl/option_greeks_exposure_check.sv
`timescale 1ns / 1ps
// Pre-trade Greeks exposure check. Each request is one of: a greeks update
// (stores delta, gamma and theta of a symbol), an order check, a fill that
// moves the saturating 64-bit totals, or a volatility index update that
// raises kill_switch on a spike. Every request gives exactly one response.
// The greeks live in one synchronous RAM, one word per symbol holding a
// valid bit and all three greeks. After reset a clearing pass writes every
// word to zero, with the request ready low. Requests are handled one at a
// time: each passes the RAM read, then the magnitude product and the
// multiplier scaling of the two-stage multiply, then the check, which
// registers the response. The next request is accepted only after that
// response is registered, so no new request is taken while one is in
// flight. The check stage waits while an earlier response still sits
// untaken in the output register.
module option_greeks_exposure_check
  import ogec_pkg::*;
#(
  parameter int unsigned SymbolCount = SymbolCountDefault,
  parameter int unsigned GreekWidth  = GreekWidthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ogec_in_if.sink     in_if,
  ogec_out_if.source  out_if,
  ogec_cfg_if.sink    cfg_if
);
  localparam int unsigned AW = $clog2(SymbolCount);
  localparam int unsigned WW = 3 * GreekWidth;

  typedef enum logic [2:0] {StClear, StIdle, StRead, StMul, StCheck} state_e;
  state_e state_q;

  // Configuration registers.
  logic [9:0]         mult_q;
  logic [62:0]        max_delta_q, max_gamma_q;
  logic signed [63:0] theta_floor_q;
  logic [31:0]        vix_pct_q;
  assign cfg_if.ready = 1'b1;

  // Captured request.
  logic [1:0]  kind_q;
  logic [7:0]  sym_q;
  logic        ask_q, base_ok_q;
  logic [23:0] qty_q;
  logic [31:0] vix_q;
  logic        in_range_q;

  logic signed [63:0] tot_d_q, tot_g_q, tot_t_q;
  logic [31:0]        prev_vix_q;
  logic [AW-1:0]      clr_q;
  result_t            res_q, res_d;

  logic        in_range;
  logic [AW-1:0] addr;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic [WW:0]   wdata;
  logic [WW:0]   rd;
  logic        wr_en;
  logic        ram_we;
  logic        clearing;
  logic        take;
  logic        known;
  logic        out_free;
  logic        fire;

  assign in_range = (32'(in_if.symbol) < SymbolCount);
  assign addr     = AW'(in_if.symbol);
  assign take     = in_if.valid && in_if.ready;
  assign wr_en    = take && (in_if.kind == KindGreeks) && in_range;
  assign in_if.ready = (state_q == StIdle);
  assign clearing = (state_q == StClear);
  assign out_free = !out_if.valid || out_if.ready;
  assign fire     = (state_q == StCheck) && out_free;

  // The read address is held on the captured symbol while a request is in
  // flight, so the read data stays steady through the multiply stages.
  assign raddr  = (state_q == StIdle) ? addr : AW'(sym_q);
  assign ram_we = wr_en || clearing;
  assign waddr  = clearing ? clr_q : addr;
  assign wdata  = clearing ? '0 : {1'b1, in_if.delta_in, in_if.gamma_in, in_if.theta_in};

  ogec_ram #(.Width(WW + 1), .Depth(SymbolCount)) u_ram (
    .clk_i, .we_i(ram_we), .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rd)
  );

  assign known = in_range_q && rd[WW];

  // Unknown symbols use delta 1.0 (Q16) with multiplier one.
  logic signed [GreekWidth+1:0] gd, gg, gt;
  logic [9:0] emult;
  always_comb begin
    if (known) begin
      gd = $signed({{2{rd[WW-1]}}, rd[WW-1 -: GreekWidth]});
      gg = $signed({{2{rd[2*GreekWidth-1]}}, rd[2*GreekWidth-1 -: GreekWidth]});
      gt = $signed({{2{rd[GreekWidth-1]}}, rd[GreekWidth-1:0]});
      emult = mult_q;
    end else begin
      gd = (GreekWidth+2)'(65536);
      gg = '0;
      gt = '0;
      emult = 10'd1;
    end
  end

  logic signed [63:0] ed, eg, et;
  ogec_expo #(.GreekWidth(GreekWidth)) u_ed (.clk_i, .greek_i(gd), .qty_i(qty_q),
    .ask_i(ask_q), .mult_i(emult), .expo_o(ed));
  ogec_expo #(.GreekWidth(GreekWidth)) u_eg (.clk_i, .greek_i(gg), .qty_i(qty_q),
    .ask_i(ask_q), .mult_i(emult), .expo_o(eg));
  ogec_expo #(.GreekWidth(GreekWidth)) u_et (.clk_i, .greek_i(gt), .qty_i(qty_q),
    .ask_i(ask_q), .mult_i(emult), .expo_o(et));

  logic signed [63:0] pd, pg, pt;
  assign pd = sat_add(tot_d_q, ed);
  assign pg = sat_add(tot_g_q, eg);
  assign pt = sat_add(tot_t_q, et);

  // Volatility spike compare, operands registered ahead of the check.
  logic [54:0] vlhs_q;
  logic [63:0] vrhs_q;
  logic        vgo_q;

  // Response of the request in the check stage.
  always_comb begin
    res_d = '0;
    case (kind_q)
      KindOrder: begin
        if (!base_ok_q) res_d.reject_reason = RsnBase;
        else if (mag(pd) > {1'b0, max_delta_q}) res_d.reject_reason = RsnDelta;
        else if (mag(pg) > {1'b0, max_gamma_q}) res_d.reject_reason = RsnGamma;
        else if (pt < theta_floor_q) res_d.reject_reason = RsnTheta;
        else res_d.accepted = 1'b1;
      end
      KindVix: res_d.kill_switch = vgo_q && (64'(vlhs_q) >= vrhs_q);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      clr_q <= '0;
      mult_q <= 10'd100;
      max_delta_q <= '0;
      max_gamma_q <= '0;
      theta_floor_q <= '0;
      vix_pct_q <= '0;
      tot_d_q <= '0;
      tot_g_q <= '0;
      tot_t_q <= '0;
      prev_vix_q <= '0;
      res_q <= '0;
      out_if.valid <= 1'b0;
    end else begin
      if (cfg_if.valid) begin
        case (cfg_if.index)
          CfgMult:     mult_q <= cfg_if.data[9:0];
          CfgMaxDelta: max_delta_q <= cfg_if.data[62:0];
          CfgMaxGamma: max_gamma_q <= cfg_if.data[62:0];
          CfgThetaFlr: theta_floor_q <= $signed(cfg_if.data);
          CfgVixPct:   vix_pct_q <= cfg_if.data[31:0];
          default: ;
        endcase
      end
      if (fire) out_if.valid <= 1'b1;
      else if (out_if.valid && out_if.ready) out_if.valid <= 1'b0;
      case (state_q)
        StClear: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == AW'(SymbolCount - 1)) state_q <= StIdle;
        end
        StIdle: if (take) begin
          state_q <= StRead;
        end
        StRead: state_q <= StMul;
        StMul: state_q <= StCheck;
        StCheck: if (out_free) begin
          res_q <= res_d;
          case (kind_q)
            KindFill: begin
              tot_d_q <= pd;
              tot_g_q <= pg;
              tot_t_q <= pt;
            end
            KindVix: prev_vix_q <= vix_q;
            default: ;
          endcase
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      kind_q     <= in_if.kind;
      sym_q      <= in_if.symbol;
      ask_q      <= in_if.side;
      qty_q      <= in_if.quantity;
      base_ok_q  <= in_if.base_ok;
      vix_q      <= in_if.vix_level;
      in_range_q <= in_range;
    end
    if (state_q == StMul) begin
      vgo_q  <= (prev_vix_q != 32'd0) && (vix_q >= prev_vix_q);
      vlhs_q <= 55'(vix_q - prev_vix_q) * 55'(PctScale);
      vrhs_q <= 64'(vix_pct_q) * 64'(prev_vix_q);
    end
  end

  assign out_if.accepted      = res_q.accepted;
  assign out_if.reject_reason = res_q.reject_reason;
  assign out_if.kill_switch   = res_q.kill_switch;

  // A response is only ever raised from the check stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_if.valid) |-> $past(state_q) == StCheck) else $error("stray response");
  // An accepted order carries no reason.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.accepted |-> out_if.reject_reason == RsnNone)
    else $error("accepted with reason");
  // Kill only comes from a volatility request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && kind_q != KindVix |=> !res_q.kill_switch)
    else $error("kill on wrong kind");
  // A waiting response holds steady until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> out_if.valid && $stable(res_q))
    else $error("response changed while waiting");
endmodule

// File: rtl/ogec_ram.sv
`timescale 1ns / 1ps
module ogec_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// File: rtl/ogec_expo.sv
`timescale 1ns / 1ps
// Signed greek times quantity times multiplier, saturated to +-(2^63-1).
// Two register stages: magnitude product, then multiplier scaling.
module ogec_expo
  import ogec_pkg::*;
#(
  parameter int unsigned GreekWidth = GreekWidthDefault
) (
  input  logic                         clk_i,
  input  logic signed [GreekWidth+1:0] greek_i,
  input  logic [23:0]                  qty_i,
  input  logic                         ask_i,
  input  logic [9:0]                   mult_i,
  output logic signed [63:0]           expo_o
);
  localparam int unsigned PW = GreekWidth + 26;
  logic [GreekWidth+1:0] gmag;
  logic [PW-1:0]         prod_q;
  logic                  neg_q;
  logic [9:0]            mult_q;
  logic [PW+9:0]         full;
  logic [62:0]           m;
  logic signed [63:0]    expo_d;

  assign gmag = greek_i[GreekWidth+1] ? (~greek_i + 1'b1) : greek_i;

  always_ff @(posedge clk_i) begin
    prod_q <= PW'(gmag) * PW'(qty_i);
    neg_q  <= greek_i[GreekWidth+1] ^ ask_i;
    mult_q <= mult_i;
    expo_o <= expo_d;
  end

  always_comb begin
    full = (PW+10)'(prod_q) * (PW+10)'(mult_q);
    if (full > (PW+10)'(SMax)) m = SMax[62:0];
    else m = full[62:0];
    expo_d = neg_q ? -$signed({1'b0, m}) : $signed({1'b0, m});
  end
endmodule
